/* sv/sstf_disk_request_scheduler_core_defines.svh */
// Assertion macros used by the SSTF scheduler top level.
`ifndef SSTF_DISK_REQUEST_SCHEDULER_CORE_DEFINES_SVH
`define SSTF_DISK_REQUEST_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SSTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SSTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sstf_pkg.sv */
// Types, codes and helpers shared by the SSTF scheduler modules.
`default_nettype none

package sstf_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int TRACKS          = 1024;
    localparam int REQ_W           = 4;
    localparam int TRK_W           = 10;

    typedef enum logic
    {
        CMD_SUBMIT = 1'b0,
        CMD_RETIRE = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_OK             = 2'd0,
        ST_FULL           = 2'd1,
        ST_DUP            = 2'd2,
        ST_RETIRE_REFUSED = 2'd3
    } status_t;

    typedef enum logic
    {
        REG_QUEUE_LIMIT     = 1'b0,
        REG_REQUESTER_COUNT = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic [REQ_W-1:0] req;
        logic [TRK_W-1:0] trk;
    } entry_t;

    // running result of the scan as it walks down the cell row
    typedef struct packed
    {
        logic             hit;   // some valid entry belongs to the requester
        logic [TRK_W-1:0] seek;  // best seek distance so far
        entry_t           ent;   // entry holding that distance
    } acc_t;

    // broadcast from the controller to every cell
    typedef struct packed
    {
        logic             upd;
        logic             shift;
        logic             ins;
        logic [REQ_W-1:0] who;
        logic [TRK_W-1:0] head;
        entry_t           new_ent;
    } cell_ctrl_t;

    function automatic logic [TRK_W-1:0] abs_diff(input logic [TRK_W-1:0] a,
                                                  input logic [TRK_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

/* sv/sstf_cell.sv */
// One queue slot: holds an entry, folds it into the scan, shifts on removal.
`default_nettype none

module sstf_cell
    import sstf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int POS   = 0
)
(
    input  logic                       clk,
    input  cell_ctrl_t                 ctrl,
    input  logic [$clog2(DEPTH+1)-1:0] cnt,
    input  logic [$clog2(DEPTH+1)-1:0] wr_pos,
    input  logic [$clog2(DEPTH)-1:0]   best_idx,
    input  entry_t                     nbr_ent,
    output entry_t                     ent,
    input  acc_t                       acc_in,
    input  logic [$clog2(DEPTH)-1:0]   idx_in,
    output acc_t                       acc_out,
    output logic [$clog2(DEPTH)-1:0]   idx_out
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam logic [CW-1:0] MY_POS   = CW'(POS);
    localparam logic [CW-1:0] NEXT_POS = CW'(POS + 1);
    localparam logic [IW-1:0] MY_IDX   = IW'(POS);

    entry_t           ent_reg;
    acc_t             acc_reg;
    acc_t             acc_next;
    logic [IW-1:0]    idx_reg;
    logic [IW-1:0]    idx_next;
    logic             valid;
    logic             take;
    logic [TRK_W-1:0] my_seek;

    assign valid   = (MY_POS < cnt);
    assign my_seek = abs_diff(ent_reg.trk, ctrl.head);
    // first valid slot always seeds; later ones win only on a strictly shorter seek
    assign take    = valid && ((POS == 0) || (my_seek < acc_in.seek));

    always_comb
    begin
        acc_next     = acc_in;
        idx_next     = idx_in;
        acc_next.hit = acc_in.hit | (valid && (ent_reg.req == ctrl.who));
        if (take)
        begin
            acc_next.seek = my_seek;
            acc_next.ent  = ent_reg;
            idx_next      = MY_IDX;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        idx_reg <= idx_next;
        if (ctrl.upd)
        begin
            if (ctrl.shift && (MY_IDX >= best_idx) && (NEXT_POS < cnt))
            begin
                ent_reg <= nbr_ent;
            end
            if (ctrl.ins && (MY_POS == wr_pos))
            begin
                ent_reg <= ctrl.new_ent;
            end
        end
    end

    assign ent     = ent_reg;
    assign acc_out = acc_reg;
    assign idx_out = idx_reg;

endmodule

`default_nettype wire

/* sv/sstf_disk_request_scheduler_core.sv */
// SSTF disk request scheduler top level: controller, cell row and stream ports.
// An accepted beat starts a scan (S_SCAN); the decision (S_DECIDE) is registered as the result beat.
// A new beat is taken only back in S_IDLE, and S_DECIDE waits while an earlier result beat is not taken.
//   The scan accumulator ripples one cell per cycle down the row of slots.
// Reset: queue empty, head at track 0, queue limit 3, active requesters 5;
//   slot contents are not cleared, only slots below the count are ever read.
`default_nettype none

`include "sstf_disk_request_scheduler_core_defines.svh"

module sstf_disk_request_scheduler_core
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] requester_id, [13:4] track, [15:14] zero
    input  logic [0:0]  s_tuser,   // [0] command
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] served_requester, [13:4] served_track, rest zero
    output logic [2:0]  m_tuser,   // [1:0] status, [2] served
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam logic [IW-1:0] LAST_SCAN = IW'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0]
    {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } state_t;

    // control and architectural state
    state_t           state_reg, state_next;
    logic [IW-1:0]    scan_cnt_reg;
    logic [CW-1:0]    count_reg;
    logic [TRK_W-1:0] head_reg;
    logic [4:0]       active_reg;
    logic [3:0]       qlim_reg;
    logic             m_tvalid_reg;

    // latched item
    cmd_t             cmd_reg;
    logic [REQ_W-1:0] who_reg;
    logic [TRK_W-1:0] trk_reg;
    logic [TRK_W-1:0] trk_in;

    // result payload
    status_t          status_reg;
    logic             served_reg;
    entry_t           served_ent_reg;

    // cell row wiring
    entry_t           ent_w [QUEUE_DEPTH];
    acc_t             acc_w [QUEUE_DEPTH+1];
    logic [IW-1:0]    idx_w [QUEUE_DEPTH+1];
    cell_ctrl_t       ctrl;
    logic [CW-1:0]    wr_pos;

    // decision
    logic             decide_fire;
    logic [CW-1:0]    lim;
    status_t          status_next;
    logic             ins;
    logic [4:0]       active_next;
    logic [CW-1:0]    cnt1;
    logic             serve;
    logic             pick_new;
    logic [TRK_W-1:0] new_dist;
    entry_t           srv_ent;
    logic [CW-1:0]    count_next;

    assign s_tready  = (state_reg == S_IDLE);
    // register writes only between items, never against a decision
    assign cfg_ready = (state_reg == S_IDLE);

    // tracks past the end of the disk land on the last track
    assign trk_in = (32'(s_tdata[13:4]) > (TRACKS - 1)) ? TRK_W'(TRACKS - 1) : s_tdata[13:4];

    assign acc_w[0] = '0;
    assign idx_w[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t nbr;
            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign nbr = ctrl.new_ent;  // never shifted in: no slot above the last
            end
            else
            begin : g_body
                assign nbr = ent_w[gi+1];
            end
            sstf_cell #(
                .DEPTH (QUEUE_DEPTH),
                .POS   (gi)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .cnt      (count_reg),
                .wr_pos   (wr_pos),
                .best_idx (idx_w[QUEUE_DEPTH]),
                .nbr_ent  (nbr),
                .ent      (ent_w[gi]),
                .acc_in   (acc_w[gi]),
                .idx_in   (idx_w[gi]),
                .acc_out  (acc_w[gi+1]),
                .idx_out  (idx_w[gi+1])
            );
        end
    endgenerate

    // Decision once the scan result has reached the end of the row.
    // The new entry is last in queue order, so it wins only on a strictly
    // shorter seek than the best of the existing queue.
    always_comb
    begin
        decide_fire = (state_reg == S_DECIDE) && (!m_tvalid_reg || m_tready);

        if (qlim_reg == 4'd0)
        begin
            lim = CW'(1);
        end
        else if (32'(qlim_reg) > QUEUE_DEPTH)
        begin
            lim = CW'(QUEUE_DEPTH);
        end
        else
        begin
            lim = CW'(qlim_reg);
        end

        status_next = ST_OK;
        ins         = 1'b0;
        active_next = active_reg;
        if (cmd_reg == CMD_SUBMIT)
        begin
            if (count_reg >= lim)
            begin
                status_next = ST_FULL;
            end
            else if (acc_w[QUEUE_DEPTH].hit)
            begin
                status_next = ST_DUP;
            end
            else
            begin
                ins = 1'b1;
            end
        end
        else
        begin
            if (acc_w[QUEUE_DEPTH].hit)
            begin
                status_next = ST_RETIRE_REFUSED;
            end
            else if (active_reg != 5'd0)
            begin
                active_next = active_reg - 5'd1;
            end
        end

        cnt1  = count_reg + {{(CW-1){1'b0}}, ins};
        serve = (status_next == ST_OK) && (cnt1 != '0) &&
                ((cnt1 >= lim) || (32'(cnt1) >= 32'(active_next)));

        new_dist = abs_diff(trk_reg, head_reg);
        pick_new = ins && ((count_reg == '0) || (new_dist < acc_w[QUEUE_DEPTH].seek));
        srv_ent  = pick_new ? entry_t'{req: who_reg, trk: trk_reg} : acc_w[QUEUE_DEPTH].ent;

        count_next = cnt1 - {{(CW-1){1'b0}}, serve};

        ctrl.upd     = decide_fire;
        ctrl.shift   = serve && !pick_new;
        ctrl.ins     = ins;
        ctrl.who     = who_reg;
        ctrl.head    = head_reg;
        ctrl.new_ent = entry_t'{req: who_reg, trk: trk_reg};
        // after removing an old entry the new one lands one slot lower
        wr_pos       = ctrl.shift ? (count_reg - CW'(1)) : count_reg;

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == LAST_SCAN)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (decide_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            count_reg    <= '0;
            head_reg     <= '0;
            active_reg   <= 5'd5;
            qlim_reg     <= 4'd3;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + IW'(1);
            end
            else
            begin
                scan_cnt_reg <= '0;
            end

            if (decide_fire)
            begin
                m_tvalid_reg <= 1'b1;
                if (status_next == ST_OK)
                begin
                    count_reg  <= count_next;
                    active_reg <= active_next;
                    if (serve)
                    begin
                        head_reg <= srv_ent.trk;
                    end
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            // register writes arrive only while idle
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_QUEUE_LIMIT:     qlim_reg   <= cfg_data[3:0];
                    REG_REQUESTER_COUNT: active_reg <= cfg_data;
                    default:             qlim_reg   <= qlim_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= cmd_t'(s_tuser[0]);
            who_reg <= s_tdata[3:0];
            trk_reg <= trk_in;
        end
        if (decide_fire)
        begin
            status_reg     <= status_next;
            served_reg     <= serve;
            served_ent_reg <= serve ? srv_ent : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, served_ent_reg.trk, served_ent_reg.req};
    assign m_tuser  = {served_reg, status_reg};

    // checks
    `SSTF_ASSERT_NOW(a_count_bound, 1'b1, 32'(count_reg) <= QUEUE_DEPTH, "queue count over depth")
    `SSTF_ASSERT_NOW(a_served_ok, m_tvalid_reg && served_reg, status_reg == ST_OK, "served on refused item")
    `SSTF_ASSERT_NEXT(a_accept_scan, s_tvalid && s_tready, state_reg == S_SCAN, "accepted item did not start scan")
    `SSTF_ASSERT_NEXT(a_refuse_hold, decide_fire && (status_next != ST_OK), count_reg == $past(count_reg), "refused item changed queue")

endmodule

`default_nettype wire
